>>> sv/pfad_pkg.sv
`timescale 1ns / 1ps
// pfad_pkg: constants, types and entry layout of the page frame allocator
// depends on nothing; used by pfad_if, pfad_frames and the top level
package pfad_pkg;

    localparam int FRAME_COUNT     = 32;
    localparam int DIRECTORY_COUNT = 4;
    localparam int ENTRIES_PER_DIR = 1024;

    localparam int FRAME_IDX_W = $clog2(FRAME_COUNT);
    localparam int CNT_W       = $clog2(FRAME_COUNT + 1);
    localparam int DIR_DEPTH   = DIRECTORY_COUNT * ENTRIES_PER_DIR;
    localparam int ADDR_W      = $clog2(DIR_DEPTH);

    localparam int MODE_W      = 2;
    localparam int DIR_ID_W    = 2;
    localparam int VPAGE_W     = 10;
    localparam int BYTES_W     = 32;
    localparam int FRAME_OUT_W = 5;
    localparam int FREE_OUT_W  = 6;

    localparam int PAGE_SHIFT  = 22;
    localparam int NEED_W      = BYTES_W - PAGE_SHIFT + 1;

    localparam int FRAME_NUM_W = 10;
    localparam int FLAGS_W     = 8;
    localparam int ENTRY_W     = FRAME_NUM_W + FLAGS_W;
    localparam logic [FLAGS_W-1:0] FLAGS_USER = 8'h87;
    localparam int ENTRY_VALID_POS = 0;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CHECK = 2'd2
    } t_mode;

    typedef struct packed {
        logic                   take;
        logic                   release_frame;
        logic [FRAME_NUM_W-1:0] idx;
    } t_frame_req;

    typedef struct packed {
        logic [CNT_W-1:0]       free_count;
        logic                   any_free;
        logic [FRAME_IDX_W-1:0] first_free;
        logic                   idx_used;
    } t_frame_stat;

endpackage

>>> sv/pfad_if.sv
`timescale 1ns / 1ps
// pfad_req_if and pfad_res_if: valid/ready channels of the allocator
// depends on pfad_pkg for field widths
interface pfad_req_if
    import pfad_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [DIR_ID_W-1:0] directory_id;
    logic [VPAGE_W-1:0]  virtual_page;
    logic [BYTES_W-1:0]  request_bytes;

    modport source (output valid, mode, directory_id, virtual_page, request_bytes,
                    input ready);
    modport sink   (input valid, mode, directory_id, virtual_page, request_bytes,
                    output ready);
endinterface

interface pfad_res_if
    import pfad_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   ok;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic [FREE_OUT_W-1:0]  free_frames;

    modport source (output valid, ok, frame_index, free_frames, input ready);
    modport sink   (input valid, ok, frame_index, free_frames, output ready);
endinterface

>>> sv/pfad_ram.sv
`timescale 1ns / 1ps
// pfad_ram: generic single-port synchronous ram, registered read
// depends on nothing
module pfad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/pfad_frames.sv
`timescale 1ns / 1ps
// pfad_frames: frame use bitmap, free count and lowest free frame search
// depends on pfad_pkg
module pfad_frames
    import pfad_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame_req  i_req,
    output t_frame_stat o_stat
);
    logic [FRAME_COUNT-1:0] r_used;
    logic [CNT_W-1:0]       r_count;

    logic [FRAME_COUNT-1:0] free_vec;
    logic [FRAME_COUNT-1:0] low_onehot;
    logic [FRAME_IDX_W-1:0] first_idx;
    logic                   in_range;
    logic [FRAME_IDX_W-1:0] rel_idx;
    logic                   rel_used;

    assign free_vec   = ~r_used;
    assign low_onehot = free_vec & (~free_vec + FRAME_COUNT'(1));

    always_comb begin
        first_idx = '0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (low_onehot[i]) begin
                first_idx = first_idx | FRAME_IDX_W'(i);
            end
        end
    end

    assign in_range = 32'(i_req.idx) < FRAME_COUNT;
    assign rel_idx  = i_req.idx[FRAME_IDX_W-1:0];
    assign rel_used = in_range && r_used[rel_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= FRAME_COUNT'(1);
            r_count <= CNT_W'(FRAME_COUNT - 1);
        end else if (i_req.take) begin
            r_used[first_idx] <= 1'b1;
            r_count           <= r_count - CNT_W'(1);
        end else if (i_req.release_frame && rel_used) begin
            r_used[rel_idx] <= 1'b0;
            r_count         <= r_count + CNT_W'(1);
        end
    end

    assign o_stat.free_count = r_count;
    assign o_stat.any_free   = (|free_vec) && (r_count != '0);
    assign o_stat.first_free = first_idx;
    assign o_stat.idx_used   = rel_used;
endmodule

>>> sv/page_frame_allocator_with_directory_top.sv
`timescale 1ns / 1ps
// page_frame_allocator_with_directory_top: sequencer around the directory ram
// depends on pfad_pkg, pfad_if, pfad_ram, pfad_frames
//
//  channel  dir  fields                                            accepted when
//  i_req    in   mode, directory_id, virtual_page, request_bytes   valid & ready
//  o_res    out  ok, frame_index, free_frames                      valid & ready
//
// on accept the entry read is issued; in ST_EXEC, once the output register is free,
// the entry is written back (on a successful alloc or free), the bitmap updated and the result register loaded
// after reset a clearing pass zeroes all DIR_DEPTH entries of the directory ram,
// one entry a cycle, with i_req.ready low
// a result waiting in the output register stalls the write-back cycle only
module page_frame_allocator_with_directory_top
    import pfad_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pfad_req_if.sink   i_req,
    pfad_res_if.source o_res
);
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state                 r_state;
    logic [ADDR_W-1:0]      r_clr_addr;
    logic [ADDR_W-1:0]      r_slot;
    logic [MODE_W-1:0]      r_mode;
    logic                   r_dir_ok;
    logic [NEED_W-1:0]      r_need;
    logic                   r_res_valid;
    logic                   r_ok;
    logic [FRAME_OUT_W-1:0] r_frame;
    logic [FREE_OUT_W-1:0]  r_free;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_addr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;

    t_frame_req             frame_req;
    t_frame_stat            frame_stat;

    logic                   accept;
    logic                   proceed;
    logic [NEED_W-1:0]      n_need;
    logic                   n_ok;
    logic [FRAME_OUT_W-1:0] n_frame;
    logic [CNT_W-1:0]       n_count;
    logic                   ent_write;
    logic [ENTRY_W-1:0]     ent_data;
    logic [FRAME_NUM_W-1:0] ent_frame;

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && (r_state == ST_IDLE);
    assign proceed     = (r_state == ST_EXEC) && (!r_res_valid || o_res.ready);

    assign n_need = NEED_W'(i_req.request_bytes[BYTES_W-1:PAGE_SHIFT])
                  + NEED_W'(|i_req.request_bytes[PAGE_SHIFT-1:0]);

    assign ent_frame = ram_rdata[FLAGS_W +: FRAME_NUM_W];

    always_comb begin
        n_ok      = 1'b0;
        n_frame   = '0;
        n_count   = frame_stat.free_count;
        ent_write = 1'b0;
        ent_data  = '0;
        frame_req = '0;
        case (t_mode'(r_mode))
            MODE_CHECK: begin
                n_ok = 32'(frame_stat.free_count) >= 32'(r_need);
            end
            MODE_ALLOC: begin
                if (r_dir_ok && frame_stat.any_free) begin
                    n_ok           = 1'b1;
                    n_frame        = FRAME_OUT_W'(frame_stat.first_free);
                    n_count        = frame_stat.free_count - CNT_W'(1);
                    ent_write      = 1'b1;
                    ent_data       = {FRAME_NUM_W'(frame_stat.first_free), FLAGS_USER};
                    frame_req.take = proceed;
                end
            end
            MODE_FREE: begin
                frame_req.idx = ent_frame;
                if (r_dir_ok && ram_rdata[ENTRY_VALID_POS]) begin
                    n_ok                    = 1'b1;
                    n_frame                 = ent_frame[FRAME_OUT_W-1:0];
                    n_count                 = frame_stat.free_count
                                            + CNT_W'(frame_stat.idx_used);
                    ent_write               = 1'b1;
                    frame_req.release_frame = proceed;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_slot;
        ram_wdata = ent_data;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr_addr;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                ram_addr = ADDR_W'({i_req.directory_id, i_req.virtual_page});
            end
            ST_EXEC: begin
                ram_we = proceed && ent_write;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(DIR_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (proceed) begin
                        r_res_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
        if (accept) begin
            r_slot   <= ADDR_W'({i_req.directory_id, i_req.virtual_page});
            r_mode   <= i_req.mode;
            r_dir_ok <= 32'(i_req.directory_id) < DIRECTORY_COUNT;
            r_need   <= n_need;
        end
        if (proceed) begin
            r_ok    <= n_ok;
            r_frame <= n_frame;
            r_free  <= FREE_OUT_W'(n_count);
        end
    end

    pfad_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DIR_DEPTH)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    pfad_frames u_frames (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (frame_req),
        .o_stat  (frame_stat)
    );

    assign o_res.valid       = r_res_valid;
    assign o_res.ok          = r_ok;
    assign o_res.frame_index = r_frame;
    assign o_res.free_frames = r_free;
endmodule
